>>> rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the sorter rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every edge out of reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> rtl/core/ins_pkg.sv
// ---------------------------------------------------------------------------
// ins_pkg
// types and sizing constants shared by the insertion sorter modules
// ---------------------------------------------------------------------------
package ins_pkg;

   // sorter store size and derived widths
   localparam int CAPACITY = 16;
   localparam int DATA_W   = 32;
   localparam int COUNT_W  = $clog2(CAPACITY + 1);

   // queue between front and back
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // one input word as it travels through the queue
   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     last;
   } ins_item_type;

endpackage

>>> rtl/core/ins_fifo.sv
// ---------------------------------------------------------------------------
// ins_fifo
// front queue: takes input words and holds them until the sort chain is free
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ins_fifo
   import ins_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   output logic         push_ready,
   input  ins_item_type push_item,
   output logic         pop_valid,
   input  logic         pop_ready,
   output ins_item_type pop_item
);

   ins_item_type          slot_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;
   logic                  push_take;
   logic                  pop_take;

   // handshake
   assign push_ready = (count_ff != FIFO_CNT_W'(FIFO_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign push_take  = push_valid && push_ready;
   assign pop_take   = pop_valid && pop_ready;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_take) begin
         wr_ptr_in = (wr_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                : wr_ptr_ff + 1'b1;
      end
      if (pop_take) begin
         rd_ptr_in = (rd_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                : rd_ptr_ff + 1'b1;
      end
      if (push_take && !pop_take) begin
         count_in = count_ff + 1'b1;
      end else if (pop_take && !push_take) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage slots
   always_ff @(posedge clock) begin
      if (push_take) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   `ASSERT_ALWAYS(a_fifo_bound, clock, reset, count_ff <= FIFO_CNT_W'(FIFO_DEPTH))
   `ASSERT_NEXT(a_fifo_grow, clock, reset, push_take && !pop_take, count_ff == $past(count_ff) + 1'b1)
   `ASSERT_NEXT(a_fifo_idle, clock, reset, !push_take && !pop_take, $stable(count_ff))

endmodule

>>> rtl/core/ins_chain.sv
// ---------------------------------------------------------------------------
// ins_chain
// back end: parallel compare and shift insertion chain, drained in order
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ins_chain
   import ins_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  ins_item_type             in_item,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_value,
   output logic                     rsp_end,
   output logic                     rsp_overflow
);

   typedef enum logic [0:0] {
      ST_INSERT,
      ST_DRAIN
   } state_type;

   state_type                state_ff, state_in;
   logic signed [DATA_W-1:0] cell_ff [CAPACITY];
   logic signed [DATA_W-1:0] cell_in [CAPACITY];
   logic        [CAPACITY-1:0] gt;
   logic [COUNT_W-1:0]       fill_ff, fill_in;
   logic                     dropped_ff, dropped_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic                     rsp_end_ff, rsp_end_in;
   logic                     rsp_over_ff, rsp_over_in;
   logic                     take;
   logic                     full;
   logic                     out_free;

   assign in_ready     = (state_ff == ST_INSERT);
   assign take         = in_valid && in_ready;
   assign full         = (fill_ff == COUNT_W'(CAPACITY));
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_value    = rsp_value_ff;
   assign rsp_end      = rsp_end_ff;
   assign rsp_overflow = rsp_over_ff;

   // per cell compare: empty cells act as larger than anything
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         gt[i] = (COUNT_W'(i) >= fill_ff) || (cell_ff[i] > in_item.value);
      end
   end

   // control and output word
   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      dropped_in   = dropped_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_over_in  = rsp_over_ff;
      if (out_free) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_INSERT: begin
            if (take) begin
               if (full) begin
                  dropped_in = 1'b1;
               end else begin
                  fill_in = fill_ff + 1'b1;
               end
               if (in_item.last) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = cell_ff[0];
               rsp_end_in   = (fill_ff == COUNT_W'(1));
               rsp_over_in  = dropped_ff;
               fill_in      = fill_ff - 1'b1;
               if (fill_ff == COUNT_W'(1)) begin
                  state_in   = ST_INSERT;
                  dropped_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_INSERT;
         end
      endcase
   end

   // cell next values: insert shifts larger cells up, drain shifts all down
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         cell_in[i] = cell_ff[i];
      end
      if (state_ff == ST_INSERT && take && !full) begin
         if (gt[0]) begin
            cell_in[0] = in_item.value;
         end
         for (int i = 1; i < CAPACITY; i++) begin
            if (gt[i]) begin
               cell_in[i] = gt[i-1] ? cell_ff[i-1] : in_item.value;
            end
         end
      end else if (state_ff == ST_DRAIN && out_free) begin
         for (int i = 0; i < CAPACITY - 1; i++) begin
            cell_in[i] = cell_ff[i+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INSERT;
         fill_ff      <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff <= rsp_value_in;
      rsp_end_ff   <= rsp_end_in;
      rsp_over_ff  <= rsp_over_in;
   end

   // sorted cells, no reset needed
   always_ff @(posedge clock) begin
      for (int i = 0; i < CAPACITY; i++) begin
         cell_ff[i] <= cell_in[i];
      end
   end

   `ASSERT_ALWAYS(a_fill_bound, clock, reset, fill_ff <= COUNT_W'(CAPACITY))
   `ASSERT_SAME(a_drain_nonempty, clock, reset, state_ff == ST_DRAIN, fill_ff != '0)
   `ASSERT_NEXT(a_insert_grow, clock, reset, take && !full, fill_ff == $past(fill_ff) + 1'b1)

endmodule

>>> rtl/core/insertion_sorter_unit.sv
// ---------------------------------------------------------------------------
// insertion_sorter_unit
// stable ascending sorter for runs of signed 32-bit words
// ---------------------------------------------------------------------------
//  channel | direction | tdata             | side band
//  req     | in        | [31:0] value      | tlast = last of run
//  rsp     | out       | [31:0] sort value | tlast = end of run, tuser = overflow
//
//  a word that does not end a run is inserted into the chain as it is taken,
//  so runs stream in at one word per cycle through the four-entry queue
//  outside a drain; a run-ending word starts a drain of the stored words, one
//  per cycle via the output register; the queue keeps taking words meanwhile
//  reset is synchronous and clears queue and chain control; cells are not
//  cleared, only cells below the fill count are ever read
//  rsp_tready low holds the drain, and the queue fills and then stalls req
// ---------------------------------------------------------------------------
module insertion_sorter_unit
   import ins_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] sorted_value
   output logic        rsp_tlast,
   output logic [0:0]  rsp_tuser    // [0] overflow
);

   ins_item_type             push_item;
   ins_item_type             pop_item;
   logic                     pop_valid;
   logic                     pop_ready;
   logic signed [DATA_W-1:0] rsp_value;
   logic                     rsp_overflow;

   // pack the input word
   assign push_item.value = signed'(req_tdata);
   assign push_item.last  = req_tlast;

   // front queue
   ins_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_tvalid),
      .push_ready (req_tready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   // insertion chain and drain
   ins_chain u_chain (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (pop_valid),
      .in_ready     (pop_ready),
      .in_item      (pop_item),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_value    (rsp_value),
      .rsp_end      (rsp_tlast),
      .rsp_overflow (rsp_overflow)
   );

   assign rsp_tdata    = unsigned'(rsp_value);
   assign rsp_tuser[0] = rsp_overflow;

endmodule

>>> verif/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for insertion_sorter_unit: runs of signed words go in,
// a local sorter tracks each run and queues the words the unit must emit in
// ascending stable order, and every result word is compared on arrival.
// both channels idle at random, the receiver holds off once for a long
// stretch, and the sender sometimes waits for a run to drain before going on
// ---------------------------------------------------------------------------
module tb_top
   import ins_pkg::*;
;

   localparam int IDLE_LIMIT  = 4000;
   localparam int FREEZE_LEN  = 300;
   localparam int RANDOM_WORDS = 300;

   typedef struct {
      logic [31:0] value;
      logic        last;
      bit          hold;    // wait for every sorted word before offering
   } req_word_type;

   typedef struct {
      logic [31:0] value;
      logic        end_of_run;
      logic        overflow;
   } sorted_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;    // [31:0] value
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // [31:0] sorted_value
   logic        rsp_tlast;
   logic [0:0]  rsp_tuser;        // [0] overflow

   // stimulus and expectations
   req_word_type    pending_words[$];
   sorted_word_type sorted_expect[$];

   // local copy of the sorter state
   logic signed [31:0] sort_cells[CAPACITY];
   int                 fill_count;
   bit                 dropped;

   // bookkeeping
   int error_count    = 0;
   int words_in       = 0;
   int runs_done      = 0;
   int overflow_runs  = 0;
   int words_checked  = 0;
   int drain_pauses   = 0;
   int idle_cycles    = 0;
   bit req_accepted   = 1'b0;
   bit rsp_freeze     = 1'b0;
   bit req_burst      = 1'b0;
   bit rsp_burst      = 1'b0;
   int req_gap_left   = 0;
   int rsp_stall_left = 0;

   insertion_sorter_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 92) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // value flavors: full range, a narrow band with many ties, extremes
   function automatic logic [31:0] pick_value(input int flavor);
      if (flavor == 1) return $urandom_range(0, 8) - 4;
      if (flavor == 2) begin
         case ($urandom_range(0, 4))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h8000_0001;
            3: return 32'h7fff_fffe;
            default: return $urandom;
         endcase
      end
      return $urandom;
   endfunction

   task automatic push_word(input logic [31:0] v, input logic lst, input bit hold);
      req_word_type w;
      w.value = v;
      w.last  = lst;
      w.hold  = hold;
      pending_words.push_back(w);
   endtask

   task automatic report_mismatch(input string msg);
      $display("mismatch: %s", msg);
      error_count++;
   endtask

   // insert one accepted word; a run end releases the whole sorted store
   task automatic sort_insert(input logic signed [31:0] v, input logic lst);
      int              pos;
      sorted_word_type s;
      words_in++;
      if (fill_count >= CAPACITY) begin
         dropped = 1'b1;
      end else begin
         pos = fill_count;
         // strictly greater cells move up, so ties keep arrival order
         while (pos > 0 && sort_cells[pos-1] > v) begin
            sort_cells[pos] = sort_cells[pos-1];
            pos--;
         end
         sort_cells[pos] = v;
         fill_count++;
      end
      if (lst) begin
         runs_done++;
         if (dropped) overflow_runs++;
         for (int k = 0; k < fill_count; k++) begin
            s.value      = sort_cells[k];
            s.end_of_run = (k == fill_count - 1);
            s.overflow   = dropped;
            sorted_expect.push_back(s);
         end
         fill_count = 0;
         dropped    = 1'b0;
      end
   endtask

   task automatic check_sorted_word(input logic [31:0] data, input logic eor,
                                    input logic ovf);
      sorted_word_type want;
      if (sorted_expect.size() == 0) begin
         report_mismatch($sformatf("unexpected word %h", data));
      end else begin
         want = sorted_expect.pop_front();
         if (data !== want.value)
            report_mismatch($sformatf("word %0d value %h, want %h",
                                      words_checked, data, want.value));
         if (eor !== want.end_of_run)
            report_mismatch($sformatf("word %0d tlast %b, want %b",
                                      words_checked, eor, want.end_of_run));
         if (ovf !== want.overflow)
            report_mismatch($sformatf("word %0d overflow %b, want %b",
                                      words_checked, ovf, want.overflow));
         words_checked++;
      end
   endtask

   // sender: hold a word until taken, then gap or offer the next one
   always @(negedge clock) begin : drive_req
      req_word_type w;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_accepted) begin
         // word still waiting for tready
      end else if (req_gap_left > 0) begin
         req_gap_left--;
         req_tvalid <= 1'b0;
      end else if (pending_words.size() == 0 ||
                   (pending_words[0].hold && sorted_expect.size() != 0)) begin
         req_tvalid <= 1'b0;
      end else begin
         w = pending_words.pop_front();
         if (w.hold) drain_pauses++;
         req_tvalid <= 1'b1;
         req_tdata  <= w.value;
         req_tlast  <= w.last;
         req_gap_left = (req_burst || $urandom_range(0, 99) < 55) ? 0 : pick_gap();
         if (w.last && $urandom_range(0, 3) == 0) req_burst = !req_burst;
      end
   end

   // receiver: random stalls, no-stall stretches, one long hold-off
   always @(negedge clock) begin
      if (reset || rsp_freeze) begin
         rsp_tready <= 1'b0;
      end else if (rsp_stall_left > 0) begin
         rsp_stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (!rsp_burst && $urandom_range(0, 99) < 25) rsp_stall_left = pick_gap();
         if ($urandom_range(0, 149) == 0) rsp_burst = !rsp_burst;
      end
   end

   // long receiver hold-off while the sender keeps offering
   initial begin
      wait (words_in >= 120);
      @(posedge clock);
      rsp_freeze = 1'b1;
      repeat (FREEZE_LEN) @(posedge clock);
      rsp_freeze = 1'b0;
   end

   // monitor: check results, then feed accepted words to the local sorter
   always @(posedge clock) begin
      if (reset) begin
         req_accepted = 1'b0;
         fill_count   = 0;
         dropped      = 1'b0;
      end else begin
         req_accepted = req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) check_sorted_word(rsp_tdata, rsp_tlast, rsp_tuser[0]);
         if (req_accepted) sort_insert(req_tdata, req_tlast);
      end
   end

   // watchdog on cycles with no word moving on either side
   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin : main
      int       random_words;
      int       len;
      int       flavor;
      int       r;
      bit       hold;
      bit       first_run;

      // single word run at the top of the range
      push_word(32'h7fff_ffff, 1'b1, 1'b0);
      // extremes and sign boundary, after the first run has drained
      push_word(32'h0000_0001, 1'b0, 1'b1);
      push_word(32'h8000_0000, 1'b0, 1'b0);
      push_word(32'hffff_ffff, 1'b0, 1'b0);
      push_word(32'h7fff_ffff, 1'b0, 1'b0);
      push_word(32'h0000_0000, 1'b1, 1'b0);
      // ties must keep arrival order
      push_word(32'd7, 1'b0, 1'b0);
      push_word(-32'sd2, 1'b0, 1'b0);
      push_word(32'd7, 1'b1, 1'b0);
      // full store in descending order, then a last word that is dropped
      for (int i = 0; i < CAPACITY; i++) push_word(CAPACITY - i, 1'b0, 1'b0);
      push_word(32'd100, 1'b1, 1'b0);

      // random runs: mostly within capacity, some exactly full, some over
      random_words = 0;
      first_run    = 1'b1;
      while (random_words < RANDOM_WORDS) begin
         r = $urandom_range(0, 99);
         if (r < 10)      len = 1;
         else if (r < 70) len = $urandom_range(2, CAPACITY - 1);
         else if (r < 85) len = CAPACITY;
         else             len = $urandom_range(CAPACITY + 1, CAPACITY + 5);
         flavor = $urandom_range(0, 2);
         hold   = first_run || ($urandom_range(0, 7) == 0);
         for (int i = 0; i < len; i++)
            push_word(pick_value(flavor), i == len - 1, hold && i == 0);
         random_words += len;
         first_run = 1'b0;
      end

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_words.size() != 0 || req_tvalid) @(posedge clock);
      while (sorted_expect.size() != 0) @(posedge clock);
      repeat (CAPACITY + 16) @(posedge clock);

      $display("summary: %0d words in %0d runs, %0d sorted words checked, %0d runs overflowed",
               words_in, runs_done, words_checked, overflow_runs);
      $display("summary: %0d drain pauses by the sender, one %0d-cycle receiver hold-off",
               drain_pauses, FREEZE_LEN);
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
